// File: rtl/dat_pkg.sv
// Package for the digest allowlist table: request/result types, codes, defaults.
// Used by digest_allowlist_table and the bench; no dependencies of its own.
`default_nettype none

package dat_pkg;

  localparam int BUCKETS_DEFAULT = 1024;
  localparam int WAYS_DEFAULT    = 4;
  localparam int KEY_W           = 160;

  typedef enum logic [1:0] {
    OP_LOOKUP_TRUSTED = 2'd0,
    OP_ADD_TRUSTED    = 2'd1,
    OP_ADD_REVOKED    = 2'd2,
    OP_UNUSED         = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_REVOKED = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] digest_high;
    logic [63:0] digest_mid;
    logic [31:0] digest_low;
  } req_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] status;
  } rsp_t;

endpackage

`default_nettype wire

// File: rtl/dat_row_ram.sv
// One bucket-row memory: one write port, one read port, registered read data.
// No package dependencies.
`default_nettype none

module dat_row_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 643
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/digest_allowlist_table.sv
// Digest allowlist table top level: trusted and revoked 160-bit digest sets.
// Depends on dat_pkg and dat_row_ram.
`default_nettype none

// Each request, from the accepting edge to the edge that takes its result, goes
// through these steps: the bucket index (first two digest bytes modulo BUCKETS)
// goes through two registered multiplies (reciprocal, then back-multiply) and a
// compare-subtract, then one row read from each table memory, then the way
// compare and write-back. busy is low in the cycle that carries a result, so
// a new request may be started alongside it; one request is in flight at a time,
// so a row write always lands before the next row read. The result shows on
// result for exactly one cycle with done high; there is no way to hold it off.
// After reset the block runs a clearing pass over every bucket row that zeroes the
// fill count of every bucket in both tables; busy is high throughout.
module digest_allowlist_table
#(
  parameter int BUCKETS = dat_pkg::BUCKETS_DEFAULT,
  parameter int WAYS    = dat_pkg::WAYS_DEFAULT
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            start,
  output logic           busy,
  input  dat_pkg::req_t  request,
  output logic           done,
  output dat_pkg::rsp_t  result
);

  import dat_pkg::*;

  localparam int AW     = $clog2(BUCKETS);
  localparam int FILL_W = $clog2(WAYS + 1);
  localparam int ROW_W  = FILL_W + WAYS * KEY_W;
  // floor(2^32 / BUCKETS): quotient estimate is low by at most one
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / BUCKETS);
  localparam logic [16:0] BKT17 = 17'(BUCKETS);
  localparam logic [AW:0] LAST  = (AW + 1)'(BUCKETS - 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_QUOT  = 6'b000100,
    S_PROD  = 6'b001000,
    S_READ  = 6'b010000,
    S_EVAL  = 6'b100000
  } state_t;

  state_t state, state_next;

  req_t            req;
  logic [15:0]     quot;
  logic [32:0]     qb;
  logic [AW-1:0]   bucket;
  logic [AW:0]     clear_cnt;

  logic [15:0]     first_two;
  logic [47:0]     quot_prod;
  logic [16:0]     diff;
  logic [16:0]     reduced;
  logic [AW-1:0]   bucket_next;
  logic [KEY_W-1:0] key;

  logic [ROW_W-1:0] t_row, r_row, t_row_new, r_row_new;
  logic [FILL_W-1:0] t_fill, r_fill;
  logic             t_hit, r_hit, t_full, r_full;
  logic             t_we, r_we;
  logic [AW-1:0]    waddr;
  logic [ROW_W-1:0] t_wdata, r_wdata;
  rsp_t             rsp_next;

  assign first_two = req.digest_high[63:48];
  assign key       = {req.digest_high, req.digest_mid, req.digest_low};
  assign quot_prod = 48'(first_two) * 48'(RECIP);

  // remainder before correction is below twice BUCKETS
  assign diff        = {1'b0, first_two} - qb[16:0];
  assign reduced     = (diff >= BKT17) ? (diff - BKT17) : diff;
  assign bucket_next = reduced[AW-1:0];

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clear_cnt == LAST) state_next = S_IDLE;
      S_IDLE:  if (start) state_next = S_QUOT;
      S_QUOT:  state_next = S_PROD;
      S_PROD:  state_next = S_READ;
      S_READ:  state_next = S_EVAL;
      S_EVAL:  state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clear_cnt <= '0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clear_cnt <= clear_cnt + 1'b1;
      end
      done <= (state == S_EVAL);
    end
  end

  assign busy = (state != S_IDLE);

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      req <= request;
    end
    if (state == S_QUOT) begin
      quot <= quot_prod[47:32];
    end
    if (state == S_PROD) begin
      qb <= 33'(quot) * 33'(BKT17);
    end
    if (state == S_READ) begin
      bucket <= bucket_next;
    end
    if (state == S_EVAL) begin
      result <= rsp_next;
    end
  end

  // ---------------- table memories ----------------
  // Row layout: fill count on top, way w key at [w*KEY_W +: KEY_W].
  assign t_fill = t_row[ROW_W-1 -: FILL_W];
  assign r_fill = r_row[ROW_W-1 -: FILL_W];

  always_comb begin
    t_hit     = 1'b0;
    r_hit     = 1'b0;
    t_row_new = t_row;
    r_row_new = r_row;
    for (int w = 0; w < WAYS; w++) begin
      // only used ways are compared; never-written slots are never looked at
      if (FILL_W'(w) < t_fill && t_row[w*KEY_W +: KEY_W] == key) t_hit = 1'b1;
      if (FILL_W'(w) < r_fill && r_row[w*KEY_W +: KEY_W] == key) r_hit = 1'b1;
      if (FILL_W'(w) == t_fill) t_row_new[w*KEY_W +: KEY_W] = key;
      if (FILL_W'(w) == r_fill) r_row_new[w*KEY_W +: KEY_W] = key;
    end
    t_row_new[ROW_W-1 -: FILL_W] = t_fill + 1'b1;
    r_row_new[ROW_W-1 -: FILL_W] = r_fill + 1'b1;
  end

  assign t_full = (t_fill >= FILL_W'(WAYS));
  assign r_full = (r_fill >= FILL_W'(WAYS));

  // result and write-back decision
  always_comb begin
    rsp_next.hit    = 1'b0;
    rsp_next.status = ST_DONE;
    t_we            = 1'b0;
    r_we            = 1'b0;
    unique case (op_t'(req.operation))
      OP_LOOKUP_TRUSTED: rsp_next.hit = t_hit;
      OP_ADD_TRUSTED: begin
        // revoked check wins over a full bucket
        if (r_hit) begin
          rsp_next.status = ST_REVOKED;
        end else if (t_full) begin
          rsp_next.status = ST_FULL;
        end else begin
          t_we = (state == S_EVAL);
        end
      end
      OP_ADD_REVOKED: begin
        if (r_full) begin
          rsp_next.status = ST_FULL;
        end else begin
          r_we = (state == S_EVAL);
        end
      end
      default: ;
    endcase
  end

  assign waddr   = (state == S_CLEAR) ? clear_cnt[AW-1:0] : bucket;
  assign t_wdata = (state == S_CLEAR) ? '0 : t_row_new;
  assign r_wdata = (state == S_CLEAR) ? '0 : r_row_new;

  dat_row_ram #(
    .DEPTH (BUCKETS),
    .WIDTH (ROW_W)
  ) u_trusted (
    .clk   (clk),
    .we    (t_we || state == S_CLEAR),
    .waddr (waddr),
    .wdata (t_wdata),
    .raddr (bucket_next),
    .rdata (t_row)
  );

  dat_row_ram #(
    .DEPTH (BUCKETS),
    .WIDTH (ROW_W)
  ) u_revoked (
    .clk   (clk),
    .we    (r_we || state == S_CLEAR),
    .waddr (waddr),
    .wdata (r_wdata),
    .raddr (bucket_next),
    .rdata (r_row)
  );

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for digest_allowlist_table: trusted/revoked digest sets.
// Directed table, then random requests; results are checked against typed or predicted values.
// Depends on dat_pkg and the digest_allowlist_table RTL.
`timescale 1ns / 100ps

module tb;
  import dat_pkg::*;

  localparam int BUCKETS = BUCKETS_DEFAULT;
  localparam int WAYS    = WAYS_DEFAULT;
  localparam int TBL_TRUSTED = 0;
  localparam int TBL_REVOKED = 1;
  localparam int RANDOM_PHASES     = 4;
  localparam int REQS_PER_PHASE    = 350;
  localparam int HOT_BUCKETS       = 16;
  localparam int HISTORY_DEPTH     = 256;
  localparam int STALL_LIMIT       = 5000; // longer than the clearing pass
  localparam int DRAIN_CYCLES      = 12;
  localparam int MAX_REPORTED      = 40;

  // Directed keys. Bucket is the low 10 bits of the first two bytes, so
  // 16'h0405, 16'hFC05 and 16'h8405 all land in bucket 5.
  localparam logic [159:0] KEY_ZERO   = '0;
  localparam logic [159:0] KEY_ONES   = '1;
  localparam logic [159:0] KEY_B5_A   = {16'h0405, 144'd1};
  localparam logic [159:0] KEY_B5_B   = {16'hFC05, 144'd1};
  localparam logic [159:0] KEY_B5_C   = {16'h0405, 144'd2};
  localparam logic [159:0] KEY_B5_D   = {16'h8405, {144{1'b1}}};
  localparam logic [159:0] KEY_B5_E   = {16'h0005, 144'd7};
  localparam logic [159:0] KEY_B0_A   = {16'h0400, 144'd3};
  localparam logic [159:0] KEY_B0_B   = {16'hFC00, 144'd3};
  localparam logic [159:0] KEY_B0_C   = {16'h8000, {144{1'b1}}};
  localparam logic [159:0] KEY_B0_D   = {16'h0800, 144'd9};
  localparam logic [159:0] KEY_CHECKR = {80{2'b10}};

  typedef struct {
    op_t          op;
    logic [159:0] key;
    bit           typed;
    rsp_t         rsp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  req_t request = '0;
  rsp_t result;

  // Typed-in expectation travels with the request it belongs to.
  bit   typed_valid = 1'b0;
  rsp_t typed_rsp = '0;

  // Predictor state: both digest sets, bucket rows of WAYS slots.
  logic [159:0] slot_key [2][BUCKETS][WAYS];
  int unsigned  slot_fill [2][BUCKETS];

  rsp_t         expected_rsp_q[$];
  logic [159:0] digest_history[$];
  dir_row_t     dir_rows[$];
  logic [9:0]   hot_bucket [HOT_BUCKETS];

  int unsigned accepted_cnt = 0;
  int unsigned fail_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned idle_pct = 0;
  rsp_t        predicted;
  rsp_t        oldest;

  always #5 clk = ~clk;

  digest_allowlist_table #(
    .BUCKETS(BUCKETS),
    .WAYS(WAYS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result)
  );

  task automatic report_mismatch(input string what);
    if (fail_count < MAX_REPORTED) $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  function automatic int unsigned bucket_of_key(logic [159:0] key);
    return int'(key[159:144]) % BUCKETS;
  endfunction

  function automatic bit set_holds(int tbl, int unsigned bkt, logic [159:0] key);
    for (int w = 0; w < WAYS; w++)
      if (w < slot_fill[tbl][bkt] && slot_key[tbl][bkt][w] == key) return 1'b1;
    return 1'b0;
  endfunction

  function automatic status_t set_insert(int tbl, int unsigned bkt, logic [159:0] key);
    if (slot_fill[tbl][bkt] >= WAYS) return ST_FULL;
    slot_key[tbl][bkt][slot_fill[tbl][bkt]] = key;
    slot_fill[tbl][bkt]++;
    return ST_DONE;
  endfunction

  // Expected outcome of one request; updates the predictor's sets.
  function automatic rsp_t membership_outcome(req_t r);
    rsp_t         o;
    logic [159:0] key;
    int unsigned  bkt;
    o   = '0;
    key = {r.digest_high, r.digest_mid, r.digest_low};
    bkt = bucket_of_key(key);
    case (op_t'(r.operation))
      OP_LOOKUP_TRUSTED: begin
        o.hit = set_holds(TBL_TRUSTED, bkt, key);
      end
      OP_ADD_TRUSTED: begin
        // revoked check wins over a full bucket
        if (set_holds(TBL_REVOKED, bkt, key)) o.status = ST_REVOKED;
        else o.status = set_insert(TBL_TRUSTED, bkt, key);
      end
      OP_ADD_REVOKED: begin
        o.status = set_insert(TBL_REVOKED, bkt, key);
      end
      default: begin
        // unused code: no state change, zero result
      end
    endcase
    return o;
  endfunction

  // Result check first (it belongs to an older request), then the new request.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          oldest = expected_rsp_q.pop_front();
          if (result.hit !== oldest.hit)
            report_mismatch($sformatf("hit %b, expected %b", result.hit, oldest.hit));
          if (result.status !== oldest.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      result.status, oldest.status));
        end
      end
      if (start && !busy) begin
        predicted = membership_outcome(request);
        expected_rsp_q.push_back(typed_valid ? typed_rsp : predicted);
        accepted_cnt++;
      end
    end
  end

  // Watchdog: cycles with neither an accepted request nor a result.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Drive one request from a falling edge; returns at the falling edge after acceptance.
  // start stays high between back-to-back requests (one assignment per step).
  task automatic issue(input req_t r, input bit has_typed, input rsp_t typed);
    int unsigned seen;
    if ($urandom_range(99) < idle_pct) begin
      repeat ($urandom_range(8, 1)) begin
        start <= 1'b0;
        @(negedge clk);
      end
    end
    start       <= 1'b1;
    request     <= r;
    typed_valid <= has_typed;
    typed_rsp   <= typed;
    seen = accepted_cnt;
    do @(negedge clk); while (accepted_cnt == seen);
  endtask

  function automatic void add_row(op_t op, logic [159:0] key, bit typed, bit hit,
                                  status_t st);
    dir_row_t d;
    d.op    = op;
    d.key   = key;
    d.typed = typed;
    d.rsp   = '{hit: hit, status: st};
    dir_rows.push_back(d);
  endfunction

  // Random digest: reuse of earlier digests (hits, duplicates, revoked skips),
  // near misses in the same bucket, and fresh digests mostly in hot buckets.
  function automatic logic [159:0] pick_digest();
    logic [159:0] key;
    int unsigned  r;
    int unsigned  flip;
    r = $urandom_range(99);
    if (digest_history.size() > 0 && r < 40) begin
      key = digest_history[$urandom_range(digest_history.size() - 1)];
    end else if (digest_history.size() > 0 && r < 52) begin
      key  = digest_history[$urandom_range(digest_history.size() - 1)];
      flip = $urandom_range(159);
      if (flip >= 144 && flip <= 153) flip -= 20; // keep the bucket
      key[flip] = ~key[flip];
    end else begin
      key = {$urandom, $urandom, $urandom, $urandom, $urandom};
      if (r < 88) key[153:144] = hot_bucket[$urandom_range(HOT_BUCKETS - 1)];
      digest_history.push_back(key);
      if (digest_history.size() > HISTORY_DEPTH) void'(digest_history.pop_front());
    end
    return key;
  endfunction

  function automatic op_t pick_op();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return OP_LOOKUP_TRUSTED;
    if (r < 65) return OP_ADD_TRUSTED;
    if (r < 93) return OP_ADD_REVOKED;
    return OP_UNUSED;
  endfunction

  initial begin
    req_t r;
    int   phase_idle [RANDOM_PHASES];
    phase_idle = '{0, 54, 0, 32};

    for (int t = 0; t < 2; t++)
      for (int b = 0; b < BUCKETS; b++) slot_fill[t][b] = 0;

    // Empty sets, extremes and the unused code.
    add_row(OP_LOOKUP_TRUSTED, KEY_ZERO, 1, 0, ST_DONE);
    add_row(OP_LOOKUP_TRUSTED, KEY_ONES, 1, 0, ST_DONE);
    add_row(OP_UNUSED,         KEY_ONES, 1, 0, ST_DONE);
    add_row(OP_ADD_TRUSTED,    KEY_ONES, 1, 0, ST_DONE);
    add_row(OP_LOOKUP_TRUSTED, KEY_ONES, 1, 1, ST_DONE);
    // Trusted add of a revoked digest is skipped.
    add_row(OP_ADD_REVOKED,    KEY_ZERO, 1, 0, ST_DONE);
    add_row(OP_ADD_TRUSTED,    KEY_ZERO, 1, 0, ST_REVOKED);
    add_row(OP_LOOKUP_TRUSTED, KEY_ZERO, 1, 0, ST_DONE);
    // Fill trusted bucket 5 with aliasing top bits, then overflow it.
    add_row(OP_ADD_TRUSTED,    KEY_B5_A, 1, 0, ST_DONE);
    add_row(OP_ADD_TRUSTED,    KEY_B5_B, 1, 0, ST_DONE);
    add_row(OP_ADD_TRUSTED,    KEY_B5_C, 1, 0, ST_DONE);
    add_row(OP_ADD_TRUSTED,    KEY_B5_D, 1, 0, ST_DONE);
    add_row(OP_ADD_TRUSTED,    KEY_B5_E, 1, 0, ST_FULL);
    add_row(OP_LOOKUP_TRUSTED, KEY_B5_E, 1, 0, ST_DONE);
    add_row(OP_LOOKUP_TRUSTED, KEY_B5_A, 1, 1, ST_DONE);
    add_row(OP_LOOKUP_TRUSTED, KEY_B5_B, 0, 0, ST_DONE);
    // Revoked check comes before the full-bucket check.
    add_row(OP_ADD_REVOKED,    KEY_B5_E, 1, 0, ST_DONE);
    add_row(OP_ADD_TRUSTED,    KEY_B5_E, 1, 0, ST_REVOKED);
    // Duplicate add stores a second copy.
    add_row(OP_ADD_TRUSTED,    KEY_ONES, 1, 0, ST_DONE);
    // Fill revoked bucket 0 and overflow it.
    add_row(OP_ADD_REVOKED,    KEY_B0_A, 1, 0, ST_DONE);
    add_row(OP_ADD_REVOKED,    KEY_B0_B, 1, 0, ST_DONE);
    add_row(OP_ADD_REVOKED,    KEY_B0_C, 1, 0, ST_DONE);
    add_row(OP_ADD_REVOKED,    KEY_B0_D, 1, 0, ST_FULL);
    // Near miss: one bit off a stored digest.
    add_row(OP_LOOKUP_TRUSTED, KEY_B5_A ^ 160'd1, 1, 0, ST_DONE);
    add_row(OP_ADD_REVOKED,    KEY_CHECKR, 0, 0, ST_DONE);

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // The first request waits out the clearing pass on busy.
    idle_pct = 0;
    foreach (dir_rows[i]) begin
      r = {dir_rows[i].op, dir_rows[i].key};
      issue(r, dir_rows[i].typed, dir_rows[i].rsp);
    end

    // Random requests, one idling profile and one hot-bucket set per phase.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      idle_pct = phase_idle[p];
      foreach (hot_bucket[h]) hot_bucket[h] = 10'($urandom_range(BUCKETS - 1));
      for (int n = 0; n < REQS_PER_PHASE; n++) begin
        r = {pick_op(), pick_digest()};
        issue(r, 1'b0, '0);
      end
    end

    start <= 1'b0;
    while (expected_rsp_q.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
